// ===== rtl/core/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the S.BUS frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// frame format
	localparam int NUM_CHANNELS  = 16;
	localparam int FRAME_BYTES   = 25;
	localparam int BUF_BYTES     = FRAME_BYTES - 1;
	localparam int CH_BITS       = 11;
	localparam int PAYLOAD_BITS  = NUM_CHANNELS * CH_BITS;
	localparam int BUF_BITS      = BUF_BYTES * 8;
	localparam int CNT_W         = $clog2(FRAME_BYTES);
	localparam int CH_IDX_W      = $clog2(NUM_CHANNELS);
	localparam int STAT_W        = 15;

	// default for the statistics parameter of the top level
	localparam int STAT_CHANNELS_DEF = 8;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// byte codes
	localparam logic [7:0] START_BYTE     = 8'h0f;
	localparam logic [7:0] END_BYTE_ZERO  = 8'h00;
	localparam logic [4:0] END_LOW_PATTERN = 5'h03;

	// pulse encoding and statistics reset values
	localparam logic [CH_BITS-1:0] PULSE_BASE  = 11'd1000;
	localparam logic [9:0]         PULSE_SPAN  = 10'd1000;
	localparam logic [STAT_W-1:0]  STAT_MIN_RESET = 15'd32767;
	localparam logic [STAT_W-1:0]  STAT_MAX_RESET = 15'd0;

	// operation codes of an input beat
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [CH_IDX_W-1:0] channel;
		logic [CH_BITS-1:0]  pulse_value;
		logic                frame_ok;
		logic [STAT_W-1:0]   range_min;
		logic [STAT_W-1:0]   range_max;
		logic                last;
	} out_item_t;

	typedef enum logic {
		CMD_CLEAR,
		CMD_FRAME
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic                    ok;
		logic [PAYLOAD_BITS-1:0] payload;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	// end byte is zero, or its low five bits are 0x03
	function automatic logic end_byte_good(input logic [7:0] b);
		return (b == END_BYTE_ZERO) || (b[4:0] == END_LOW_PATTERN);
	endfunction

	// 1000 + v * 1000 / 2048
	function automatic logic [CH_BITS-1:0] scale_pulse(input logic [CH_BITS-1:0] v);
		logic [CH_BITS+9:0] prod;
		prod = v * PULSE_SPAN;
		return PULSE_BASE + {1'b0, prod[CH_BITS+9:CH_BITS]};
	endfunction

endpackage

// ===== rtl/core/sfr_stream_if.sv =====
// ----------------------------------------------------------------------------
// sfr_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface sfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Hunts for the start byte, collects frame bytes and queues frame and clear
// commands for the back end.
// ----------------------------------------------------------------------------
module sfr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	sfr_stream_if.sink            rx,
	input  logic                  q_full,
	output logic                  push,
	output sfr_pkg::cmd_t         push_cmd
);

	logic [sfr_pkg::CNT_W-1:0]    count_q;
	logic [sfr_pkg::BUF_BITS-1:0] buf_q;
	logic [sfr_pkg::BUF_BITS-1:0] buf_next;
	logic                         accept;
	logic                         is_byte;
	logic                         frame_done;

	assign rx.ready = ~q_full;
	assign accept   = rx.valid & rx.ready;
	assign is_byte  = (rx.payload.op == sfr_pkg::OP_BYTE);

	// newest byte enters at the top, so the first one ends at the bottom
	assign buf_next   = {rx.payload.data_byte, buf_q[sfr_pkg::BUF_BITS-1:8]};
	assign frame_done = is_byte && (count_q == sfr_pkg::CNT_W'(sfr_pkg::BUF_BYTES));

	// command towards the queue
	always_comb begin
		push             = 1'b0;
		push_cmd.kind    = sfr_pkg::CMD_FRAME;
		push_cmd.ok      = sfr_pkg::end_byte_good(rx.payload.data_byte);
		push_cmd.payload = buf_next[sfr_pkg::PAYLOAD_BITS-1:0];
		if (accept && !is_byte) begin
			push          = 1'b1;
			push_cmd.kind = sfr_pkg::CMD_CLEAR;
		end else if (accept && frame_done) begin
			push = 1'b1;
		end
	end

	// byte counter, zero while hunting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && is_byte) begin
			if (count_q == '0) begin
				if (rx.payload.data_byte == sfr_pkg::START_BYTE)
					count_q <= sfr_pkg::CNT_W'(1);
			end else if (frame_done) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + sfr_pkg::CNT_W'(1);
			end
		end
	end

	// frame byte shift line
	always_ff @(posedge clk) begin
		if (accept && is_byte && (count_q != '0))
			buf_q <= buf_next;
	end

endmodule

// ===== rtl/core/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Short command queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
module sfr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output sfr_pkg::cmd_t head_cmd
);

	sfr_pkg::cmd_t              mem_q [sfr_pkg::QUEUE_DEPTH];
	logic [sfr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sfr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sfr_pkg::QCNT_W-1:0] count_q;
	logic                       do_push;
	logic                       do_pop;

	assign full       = (count_q == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [sfr_pkg::QPTR_W-1:0] ptr_inc(
		input logic [sfr_pkg::QPTR_W-1:0] p
	);
		if (p == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + sfr_pkg::QPTR_W'(1);
	endfunction

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + sfr_pkg::QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - sfr_pkg::QCNT_W'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Carries out queued commands: clears statistics, or scales one channel per
// beat, updates the stored values and running min/max, and emits results.
// ----------------------------------------------------------------------------
module sfr_back #(
	parameter int STAT_CHANNELS = sfr_pkg::STAT_CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  sfr_pkg::cmd_t head_cmd,
	output logic          pop,
	sfr_stream_if.source  result
);

	sfr_pkg::back_state_t          state_q;
	sfr_pkg::back_state_t          state_d;
	logic [sfr_pkg::CH_IDX_W-1:0]  idx_q;
	logic [sfr_pkg::CH_BITS-1:0]   store_q [sfr_pkg::NUM_CHANNELS];
	logic [sfr_pkg::STAT_W-1:0]    min_q [STAT_CHANNELS];
	logic [sfr_pkg::STAT_W-1:0]    max_q [STAT_CHANNELS];
	sfr_pkg::out_item_t            out_q;
	logic                          out_valid_q;
	logic                          load;
	logic                          clear_stats;
	logic                          idx_last;
	logic                          is_stat;
	logic [sfr_pkg::CH_BITS-1:0]   raw;
	logic [sfr_pkg::CH_BITS-1:0]   value;
	logic [sfr_pkg::STAT_W-1:0]    value_w;
	logic [sfr_pkg::STAT_W-1:0]    cur_min;
	logic [sfr_pkg::STAT_W-1:0]    cur_max;
	logic [sfr_pkg::STAT_W-1:0]    new_min;
	logic [sfr_pkg::STAT_W-1:0]    new_max;

	assign idx_last = (idx_q == sfr_pkg::CH_IDX_W'(sfr_pkg::NUM_CHANNELS - 1));

	// next state and command handling
	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		load        = 1'b0;
		clear_stats = 1'b0;
		case (state_q)
			sfr_pkg::BK_IDLE: begin
				if (head_valid) begin
					if (head_cmd.kind == sfr_pkg::CMD_CLEAR) begin
						clear_stats = 1'b1;
						pop         = 1'b1;
					end else begin
						state_d = sfr_pkg::BK_EMIT;
					end
				end
			end
			sfr_pkg::BK_EMIT: begin
				load = !out_valid_q || result.ready;
				if (load && idx_last) begin
					pop     = 1'b1;
					state_d = sfr_pkg::BK_IDLE;
				end
			end
			default: state_d = sfr_pkg::BK_IDLE;
		endcase
	end

	// channel value: freshly scaled on a good frame, else the stored one
	assign raw     = head_cmd.payload[sfr_pkg::CH_BITS*idx_q +: sfr_pkg::CH_BITS];
	assign value   = head_cmd.ok ? sfr_pkg::scale_pulse(raw) : store_q[idx_q];
	assign value_w = sfr_pkg::STAT_W'(value);

	// select this channel's statistics
	always_comb begin
		is_stat = 1'b0;
		cur_min = sfr_pkg::STAT_MIN_RESET;
		cur_max = sfr_pkg::STAT_MAX_RESET;
		for (int j = 0; j < STAT_CHANNELS; j++) begin
			if (idx_q == sfr_pkg::CH_IDX_W'(j)) begin
				is_stat = 1'b1;
				cur_min = min_q[j];
				cur_max = max_q[j];
			end
		end
	end

	assign new_min = (value_w < cur_min) ? value_w : cur_min;
	assign new_max = (value_w > cur_max) ? value_w : cur_max;

	// state register and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfr_pkg::BK_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load)
				idx_q <= idx_q + sfr_pkg::CH_IDX_W'(1);
		end
	end

	// stored channel values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < sfr_pkg::NUM_CHANNELS; c++)
				store_q[c] <= sfr_pkg::PULSE_BASE;
		end else if (load && head_cmd.ok) begin
			store_q[idx_q] <= value;
		end
	end

	// running min and max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < STAT_CHANNELS; j++) begin
				min_q[j] <= sfr_pkg::STAT_MIN_RESET;
				max_q[j] <= sfr_pkg::STAT_MAX_RESET;
			end
		end else begin
			for (int j = 0; j < STAT_CHANNELS; j++) begin
				if (clear_stats) begin
					min_q[j] <= sfr_pkg::STAT_MIN_RESET;
					max_q[j] <= sfr_pkg::STAT_MAX_RESET;
				end else if (load && (idx_q == sfr_pkg::CH_IDX_W'(j))) begin
					min_q[j] <= new_min;
					max_q[j] <= new_max;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.channel     <= idx_q;
			out_q.pulse_value <= value;
			out_q.frame_ok    <= head_cmd.ok;
			out_q.range_min   <= is_stat ? new_min : '0;
			out_q.range_max   <= is_stat ? new_max : '0;
			out_q.last        <= idx_last;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

endmodule

// ===== rtl/core/sbus_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// S.BUS frame receiver: bytes in, sixteen scaled channel results per frame.
// ----------------------------------------------------------------------------
// One byte or clear beat is taken per clock while the two-entry command queue
// has room. A completed frame (start byte 0x0f plus 24 bytes) or a clear goes
// into the queue; the back end pops a clear straight from idle, and takes a
// frame up by moving from idle to its emit state, then gives one channel
// result per cycle through a registered output while the sink does not stall.
// A frame's results pass through the queue entry, the emit state and the
// output register. The front end goes on taking bytes of the next frame
// while the back end emits, as long as the queue has room.
module sbus_frame_receiver #(
	parameter int STAT_CHANNELS = sfr_pkg::STAT_CHANNELS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	sfr_stream_if.sink   rx,
	sfr_stream_if.source result
);

	logic          q_full;
	logic          push;
	sfr_pkg::cmd_t push_cmd;
	logic          pop;
	logic          head_valid;
	sfr_pkg::cmd_t head_cmd;

	// byte hunting and frame collection
	sfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// command queue
	sfr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// scaling, statistics and result beats
	sfr_back #(
		.STAT_CHANNELS (STAT_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.result     (result)
	);

endmodule
